/* sv/apu_pkg.sv */
`default_nettype none

package apu_pkg;

    // Longest permutation the count table covers
    localparam int MAX_LEN = 20;

    // Fixed field widths
    localparam int LEN_W  = 5;
    localparam int RANK_W = 64;
    localparam int VAL_W  = 5;
    localparam int CNT_W  = 64;

    // Counters that walk values and positions 1..MAX_LEN+1
    localparam int CTR_W = $clog2(MAX_LEN + 2);
    // Bit index into the used-value mask
    localparam int IDX_W = $clog2(MAX_LEN);

    // Count table: one row of MAX_LEN entries for each length
    localparam int TBL_DEPTH = MAX_LEN * MAX_LEN;
    localparam int TBL_AW    = $clog2(TBL_DEPTH);

    // Stream widths, padded to whole bytes
    localparam int S_TDATA_W = ((LEN_W + RANK_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VAL_W + 7) / 8) * 8;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        CMD_BAD,
        CMD_SINGLE,
        CMD_FULL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t           kind;
        logic [LEN_W-1:0]    len;
        logic [RANK_W-1:0]   rank;
    } cmd_t;

    // Front to queue
    typedef struct packed {
        logic push;
        cmd_t cmd;
    } q_push_t;

    // Queue to back
    typedef struct packed {
        logic valid;
        cmd_t cmd;
    } q_head_t;

    typedef enum logic [2:0] {
        ST_FILL_WR,
        ST_FILL_ACC,
        ST_IDLE,
        ST_FIRST_RD,
        ST_FIRST_CHK,
        ST_SCAN,
        ST_WAIT
    } state_t;

    // Table address of (length, start rank), both one-based
    function automatic logic [TBL_AW-1:0] tbl_addr(input logic [CTR_W-1:0] len,
                                                  input logic [CTR_W-1:0] pos);
        logic [TBL_AW-1:0] row;
        logic [TBL_AW-1:0] col;
        row = TBL_AW'(len - CTR_W'(1));
        col = TBL_AW'(pos - CTR_W'(1));
        return row * TBL_AW'(MAX_LEN) + col;
    endfunction

endpackage

`default_nettype wire

/* sv/apu_ram.sv */
`default_nettype none

module apu_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 400
) (
    input  wire logic                         clk,
    input  wire logic                         we,
    input  wire logic [$clog2(DEPTH)-1:0]     waddr,
    input  wire logic [WIDTH-1:0]             wdata,
    input  wire logic [$clog2(DEPTH)-1:0]     raddr,
    output logic      [WIDTH-1:0]             rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* sv/apu_front.sv */
`default_nettype none

module apu_front (
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [apu_pkg::S_TDATA_W-1:0]   s_tdata,
    input  wire logic                            table_ready,
    input  wire logic                            q_full,
    output apu_pkg::q_push_t                     wr
);

    localparam int NW = apu_pkg::LEN_W;
    localparam int RW = apu_pkg::RANK_W;

    logic [NW-1:0] len;
    logic [RW-1:0] rank;

    // Unpack the beat
    assign len  = s_tdata[NW-1:0];
    assign rank = s_tdata[NW+RW-1:NW];

    // Take beats once the table is built and the queue has room
    assign s_tready = table_ready && !q_full;

    // Sort the query into bad, single-value or full unrank
    always_comb
    begin
        wr.push     = s_tvalid && s_tready;
        wr.cmd.len  = len;
        wr.cmd.rank = rank;
        if (len == NW'(0) || len > NW'(apu_pkg::MAX_LEN) || rank == RW'(0))
        begin
            wr.cmd.kind = apu_pkg::CMD_BAD;
        end
        else if (len == NW'(1))
        begin
            wr.cmd.kind = (rank == RW'(1)) ? apu_pkg::CMD_SINGLE : apu_pkg::CMD_BAD;
        end
        else
        begin
            wr.cmd.kind = apu_pkg::CMD_FULL;
        end
    end

endmodule

`default_nettype wire

/* sv/apu_queue.sv */
`default_nettype none

module apu_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire apu_pkg::q_push_t   wr,
    output logic                    full,
    input  wire logic               pop,
    output apu_pkg::q_head_t        head
);

    localparam int PW = apu_pkg::QPTR_W;
    localparam int QW = apu_pkg::QCNT_W;
    localparam int QD = apu_pkg::QUEUE_DEPTH;

    apu_pkg::cmd_t  slot_reg [QD];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [QW-1:0]  count_reg, count_next;
    logic           push_ok;
    logic           pop_ok;

    assign full       = (count_reg == QW'(QD));
    assign head.valid = (count_reg != QW'(0));
    assign head.cmd   = slot_reg[rd_ptr_reg];

    assign push_ok = wr.push && !full;
    assign pop_ok  = pop && head.valid;

    // Advance pointers with wrap, track fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push_ok)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(QD - 1)) ? PW'(0) : wr_ptr_reg + PW'(1);
        end
        if (pop_ok)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(QD - 1)) ? PW'(0) : rd_ptr_reg + PW'(1);
        end
        if (push_ok && !pop_ok)
        begin
            count_next = count_reg + QW'(1);
        end
        else if (pop_ok && !push_ok)
        begin
            count_next = count_reg - QW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge clk)
    begin
        if (push_ok)
        begin
            slot_reg[wr_ptr_reg] <= wr.cmd;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QW'(QD))
        else $error("queue fill level above depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head.valid)
        else $error("pop from empty queue");

endmodule

`default_nettype wire

/* sv/apu_back.sv */
`default_nettype none

module apu_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire apu_pkg::q_head_t              head,
    output logic                               pop,
    output logic                               table_ready,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [apu_pkg::VAL_W-1:0]          element_value,
    output logic                               last_element,
    output logic                               bad_rank
);

    localparam int CW = apu_pkg::CTR_W;
    localparam int AW = apu_pkg::TBL_AW;
    localparam int RW = apu_pkg::RANK_W;
    localparam int KW = apu_pkg::CNT_W;
    localparam int XW = apu_pkg::IDX_W;
    localparam int VW = apu_pkg::VAL_W;
    localparam int ML = apu_pkg::MAX_LEN;

    apu_pkg::state_t state_reg, state_next;

    // Table build
    logic [CW-1:0] len_reg, len_next;
    logic [CW-1:0] r_reg, r_next;
    logic [KW-1:0] sum_reg, sum_next;

    // Query walk
    logic [CW-1:0] n_reg, n_next;
    logic [RW-1:0] c_reg, c_next;
    logic [KW-1:0] run_reg, run_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic          gd_reg, gd_next;
    logic [ML-1:0] used_reg, used_next;
    logic [CW-1:0] step_reg, step_next;
    logic [CW-1:0] v_reg, v_next;
    logic [CW-1:0] pos_reg, pos_next;

    // Output register
    logic          out_valid_reg, out_valid_next;
    logic [VW-1:0] out_value_reg, out_value_next;
    logic          out_last_reg, out_last_next;
    logic          out_bad_reg, out_bad_next;

    // Table memories: ram0 holds first-move-up counts, ram1 first-move-down
    logic          fill_we;
    logic [AW-1:0] waddr0, waddr1, raddr;
    logic [KW-1:0] wdata;
    logic [KW-1:0] rdata0, rdata1;

    // Decisions
    logic          out_free;
    logic [KW-1:0] rk;
    logic [KW-1:0] first_dn;
    logic [KW-1:0] first_tot;
    logic          first_hit;
    logic          first_down;
    logic [KW-1:0] scan_sum;
    logic          scan_hit;
    logic          v_over;
    logic [XW-1:0] vi;
    logic [ML-1:0] v_bit;
    logic          v_used;
    logic          v_skip;
    logic          last_step;
    logic [CW-1:0] len_prev;

    apu_ram #(.WIDTH(KW), .DEPTH(apu_pkg::TBL_DEPTH)) u_ram0 (
        .clk   (clk),
        .we    (fill_we),
        .waddr (waddr0),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata0)
    );

    apu_ram #(.WIDTH(KW), .DEPTH(apu_pkg::TBL_DEPTH)) u_ram1 (
        .clk   (clk),
        .we    (fill_we),
        .waddr (waddr1),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata1)
    );

    // Build: a row's down counts are prefix sums of the previous row's up
    // counts; the up count at rank r mirrors the down count at len+1-r
    assign fill_we  = (state_reg == apu_pkg::ST_FILL_WR);
    assign wdata    = (len_reg == CW'(1)) ? KW'(1) : sum_reg;
    assign waddr1   = apu_pkg::tbl_addr(len_reg, r_reg);
    assign waddr0   = apu_pkg::tbl_addr(len_reg, len_reg + CW'(1) - r_reg);
    assign len_prev = (len_reg == CW'(1)) ? CW'(1) : len_reg - CW'(1);

    // Read address follows the build position during fill, then the current walk position
    always_comb
    begin
        unique case (state_reg)
            apu_pkg::ST_FILL_WR, apu_pkg::ST_FILL_ACC:
                raddr = apu_pkg::tbl_addr(len_prev, r_reg);
            apu_pkg::ST_FIRST_RD, apu_pkg::ST_FIRST_CHK:
                raddr = apu_pkg::tbl_addr(n_reg, v_reg);
            apu_pkg::ST_SCAN:
                raddr = apu_pkg::tbl_addr(n_reg - step_reg, pos_reg + CW'(1));
            apu_pkg::ST_WAIT:
                raddr = apu_pkg::tbl_addr(n_reg - step_reg, pos_reg);
            default:
                raddr = '0;
        endcase
    end

    assign table_ready = (state_reg != apu_pkg::ST_FILL_WR) &&
                         (state_reg != apu_pkg::ST_FILL_ACC);

    assign out_free   = !out_valid_reg || out_ready;
    assign rk         = gd_reg ? rdata0 : rdata1;
    assign first_dn   = run_reg + rdata1;
    assign first_tot  = first_dn + rdata0;
    assign first_hit  = (first_tot >= c_reg);
    assign first_down = (first_dn >= c_reg);
    assign scan_sum   = run_reg + rk;
    assign scan_hit   = (scan_sum >= c_reg);
    assign v_over     = (v_reg > n_reg);
    assign vi         = XW'(v_reg - CW'(1));
    assign v_bit      = ML'(1) << vi;
    assign v_used     = !v_over && ((used_reg & v_bit) != '0);
    assign v_skip     = gd_reg ? (v_reg > prev_reg) : (v_reg < prev_reg);
    assign last_step  = (step_reg == n_reg - CW'(1));

    assign pop = (state_reg == apu_pkg::ST_IDLE) && head.valid &&
                 ((head.cmd.kind == apu_pkg::CMD_FULL) || out_free);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            apu_pkg::ST_FILL_WR:
            begin
                if (r_reg == len_reg)
                begin
                    if (len_reg == CW'(ML))
                    begin
                        state_next = apu_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = apu_pkg::ST_FILL_ACC;
                end
            end
            apu_pkg::ST_FILL_ACC:
                state_next = apu_pkg::ST_FILL_WR;
            apu_pkg::ST_IDLE:
            begin
                if (pop && head.cmd.kind == apu_pkg::CMD_FULL)
                begin
                    state_next = apu_pkg::ST_FIRST_RD;
                end
            end
            apu_pkg::ST_FIRST_RD:
                state_next = apu_pkg::ST_FIRST_CHK;
            apu_pkg::ST_FIRST_CHK:
            begin
                if (out_free)
                begin
                    if (first_hit)
                    begin
                        state_next = apu_pkg::ST_SCAN;
                    end
                    else if (v_reg == n_reg)
                    begin
                        state_next = apu_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = apu_pkg::ST_FIRST_RD;
                    end
                end
            end
            apu_pkg::ST_SCAN:
            begin
                if (v_over)
                begin
                    if (out_free && last_step)
                    begin
                        state_next = apu_pkg::ST_IDLE;
                    end
                end
                else if (!v_used && !v_skip)
                begin
                    state_next = apu_pkg::ST_WAIT;
                end
            end
            apu_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    state_next = (scan_hit && last_step) ? apu_pkg::ST_IDLE
                                                         : apu_pkg::ST_SCAN;
                end
            end
            default:
                state_next = apu_pkg::ST_IDLE;
        endcase
    end

    // Datapath and result beats
    always_comb
    begin
        len_next       = len_reg;
        r_next         = r_reg;
        sum_next       = sum_reg;
        n_next         = n_reg;
        c_next         = c_reg;
        run_next       = run_reg;
        prev_next      = prev_reg;
        gd_next        = gd_reg;
        used_next      = used_reg;
        step_next      = step_reg;
        v_next         = v_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_value_next = out_value_reg;
        out_last_next  = out_last_reg;
        out_bad_next   = out_bad_reg;

        unique case (state_reg)
            apu_pkg::ST_FILL_WR:
            begin
                if (r_reg == len_reg && len_reg != CW'(ML))
                begin
                    len_next = len_reg + CW'(1);
                    r_next   = CW'(1);
                    sum_next = '0;
                end
            end
            apu_pkg::ST_FILL_ACC:
            begin
                sum_next = sum_reg + rdata0;
                r_next   = r_reg + CW'(1);
            end
            apu_pkg::ST_IDLE:
            begin
                if (pop)
                begin
                    case (head.cmd.kind)
                        apu_pkg::CMD_FULL:
                        begin
                            n_next   = CW'(head.cmd.len);
                            c_next   = head.cmd.rank;
                            run_next = '0;
                            v_next   = CW'(1);
                        end
                        apu_pkg::CMD_SINGLE:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = VW'(1);
                            out_last_next  = 1'b1;
                            out_bad_next   = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_last_next  = 1'b1;
                            out_bad_next   = 1'b1;
                        end
                    endcase
                end
            end
            apu_pkg::ST_FIRST_CHK:
            begin
                if (out_free)
                begin
                    if (first_hit)
                    begin
                        // Pick the opening value and its first move
                        prev_next      = v_reg;
                        used_next      = v_bit;
                        gd_next        = first_down;
                        run_next       = first_down ? run_reg : first_dn;
                        step_next      = CW'(1);
                        v_next         = CW'(1);
                        pos_next       = '0;
                        out_valid_next = 1'b1;
                        out_value_next = VW'(v_reg);
                        out_last_next  = 1'b0;
                        out_bad_next   = 1'b0;
                    end
                    else
                    begin
                        run_next = first_tot;
                        v_next   = v_reg + CW'(1);
                        if (v_reg == n_reg)
                        begin
                            // Rank beyond the total count
                            out_valid_next = 1'b1;
                            out_value_next = '0;
                            out_last_next  = 1'b1;
                            out_bad_next   = 1'b1;
                        end
                    end
                end
            end
            apu_pkg::ST_SCAN:
            begin
                if (v_over)
                begin
                    // No value fits: emit zero and move on
                    if (out_free)
                    begin
                        prev_next      = '0;
                        gd_next        = !gd_reg;
                        step_next      = step_reg + CW'(1);
                        v_next         = CW'(1);
                        pos_next       = '0;
                        out_valid_next = 1'b1;
                        out_value_next = '0;
                        out_last_next  = last_step;
                        out_bad_next   = 1'b0;
                    end
                end
                else if (v_used)
                begin
                    v_next = v_reg + CW'(1);
                end
                else if (v_skip)
                begin
                    pos_next = pos_reg + CW'(1);
                    v_next   = v_reg + CW'(1);
                end
                else
                begin
                    pos_next = pos_reg + CW'(1);
                end
            end
            apu_pkg::ST_WAIT:
            begin
                if (out_free)
                begin
                    if (scan_hit)
                    begin
                        used_next      = used_reg | v_bit;
                        prev_next      = v_reg;
                        gd_next        = !gd_reg;
                        step_next      = step_reg + CW'(1);
                        v_next         = CW'(1);
                        pos_next       = '0;
                        out_valid_next = 1'b1;
                        out_value_next = VW'(v_reg);
                        out_last_next  = last_step;
                        out_bad_next   = 1'b0;
                    end
                    else
                    begin
                        run_next = scan_sum;
                        v_next   = v_reg + CW'(1);
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= apu_pkg::ST_FILL_WR;
            len_reg       <= CW'(1);
            r_reg         <= CW'(1);
            sum_reg       <= '0;
            run_reg       <= '0;
            prev_reg      <= '0;
            gd_reg        <= 1'b0;
            used_reg      <= '0;
            step_reg      <= '0;
            v_reg         <= '0;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            len_reg       <= len_next;
            r_reg         <= r_next;
            sum_reg       <= sum_next;
            run_reg       <= run_next;
            prev_reg      <= prev_next;
            gd_reg        <= gd_next;
            used_reg      <= used_next;
            step_reg      <= step_next;
            v_reg         <= v_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        c_reg         <= c_next;
        out_value_reg <= out_value_next;
        out_last_reg  <= out_last_next;
        out_bad_reg   <= out_bad_next;
    end

    assign out_valid     = out_valid_reg;
    assign element_value = out_value_reg;
    assign last_element  = out_last_reg;
    assign bad_rank      = out_bad_reg;

    a_quiet_fill: assert property (@(posedge clk) disable iff (!rst_n)
        !table_ready |-> !out_valid_reg)
        else $error("result beat while the table is being built");

    a_run_below_rank: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apu_pkg::ST_FIRST_CHK || state_reg == apu_pkg::ST_SCAN ||
         state_reg == apu_pkg::ST_WAIT) |-> run_reg < c_reg)
        else $error("running count reached the rank without a pick");

    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apu_pkg::ST_WAIT) |->
            (pos_reg != CW'(0) && pos_reg <= n_reg - step_reg))
        else $error("candidate position outside the remaining values");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == apu_pkg::ST_SCAN || state_reg == apu_pkg::ST_WAIT) |->
            (step_reg != CW'(0) && step_reg < n_reg))
        else $error("position index outside the permutation");

endmodule

`default_nettype wire

/* sv/alternating_permutation_unrank.sv */
// Channel   Dir  Beat contents
// s_axis    in   tdata: seq_length[4:0], rank[68:5], zero pad to 72 bits
// m_axis    out  tdata: element_value[4:0], zero pad to 8 bits;
//                tlast: last_element; tuser: bad_rank
//
// After reset the count table is filled one length at a time, tready low.
// Bad length, rank zero or length one: answered from idle with a single beat. Any other query,
// a rank beyond the total included, walks the candidate values with one table read
// and one add and compare per candidate value through the single read port.
// A two-entry command queue lets the front take queries while the back works;
// the output register holds a beat under m_axis_tready low and the walk waits.
`default_nettype none

module alternating_permutation_unrank (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // seq_length[4:0], rank[68:5], pad
    input  wire logic [apu_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // element_value[4:0], pad
    output logic      [apu_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    output logic                                 m_axis_tlast,
    // bad_rank
    output logic                                 m_axis_tuser
);

    localparam int PADW = apu_pkg::M_TDATA_W - apu_pkg::VAL_W;

    apu_pkg::q_push_t          q_wr;
    apu_pkg::q_head_t          q_head;
    logic                      q_full;
    logic                      q_pop;
    logic                      table_ready;
    logic [apu_pkg::VAL_W-1:0] element_value;

    apu_front u_front (
        .s_tvalid    (s_axis_tvalid),
        .s_tready    (s_axis_tready),
        .s_tdata     (s_axis_tdata),
        .table_ready (table_ready),
        .q_full      (q_full),
        .wr          (q_wr)
    );

    apu_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .wr    (q_wr),
        .full  (q_full),
        .pop   (q_pop),
        .head  (q_head)
    );

    apu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (q_head),
        .pop           (q_pop),
        .table_ready   (table_ready),
        .out_ready     (m_axis_tready),
        .out_valid     (m_axis_tvalid),
        .element_value (element_value),
        .last_element  (m_axis_tlast),
        .bad_rank      (m_axis_tuser)
    );

    assign m_axis_tdata = {{PADW{1'b0}}, element_value};

endmodule

`default_nettype wire

/* test/alternating_permutation_unrank_test.sv */
`default_nettype none

module alternating_permutation_unrank_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_LEN   = apu_pkg::MAX_LEN;
    localparam int LEN_W     = apu_pkg::LEN_W;
    localparam int RANK_W    = apu_pkg::RANK_W;
    localparam int VAL_W     = apu_pkg::VAL_W;
    localparam int S_TDATA_W = apu_pkg::S_TDATA_W;
    localparam int M_TDATA_W = apu_pkg::M_TDATA_W;

    // One output beat as the block should present it
    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic             last;
        logic             bad;
    } zz_beat_t;

    logic                 clk;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 m_axis_tlast;
    logic                 m_axis_tuser;

    // Zigzag counts: [length][start rank][0 = first move up, 1 = down]
    logic [63:0] zz_count [0:MAX_LEN][0:MAX_LEN][0:1];
    zz_beat_t    expected_beats[$];
    zz_beat_t    head_beat;

    bit idle_en;
    int out_stall_left;
    int error_count;
    int query_count;
    int bad_query_count;
    int beat_count;

    alternating_permutation_unrank u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Build the zigzag count table that the block fills after reset, by direct sums
    function automatic void build_zigzag_counts();
        logic [63:0] up_sum;
        logic [63:0] down_sum;
        for (int l = 0; l <= MAX_LEN; l++)
            for (int r = 0; r <= MAX_LEN; r++)
            begin
                zz_count[l][r][0] = '0;
                zz_count[l][r][1] = '0;
            end
        zz_count[1][1][0] = 64'd1;
        zz_count[1][1][1] = 64'd1;
        zz_count[2][1][0] = 64'd1;
        zz_count[2][2][1] = 64'd1;
        for (int l = 3; l <= MAX_LEN; l++)
            for (int r = 1; r <= l; r++)
            begin
                up_sum   = '0;
                down_sum = '0;
                for (int k = r; k < l; k++)
                    up_sum += zz_count[l-1][k][1];
                for (int k = 1; k < r; k++)
                    down_sum += zz_count[l-1][k][0];
                zz_count[l][r][0] = up_sum;
                zz_count[l][r][1] = down_sum;
            end
    endfunction

    // Number of zigzag permutations of 1..n, for n of 2 and up
    function automatic logic [63:0] zigzag_total(input int n);
        logic [63:0] sum;
        sum = '0;
        for (int i = 1; i <= n; i++)
            sum += zz_count[n][i][0] + zz_count[n][i][1];
        return sum;
    endfunction

    function automatic void push_bad();
        zz_beat_t b;
        b.value = '0;
        b.last  = 1'b1;
        b.bad   = 1'b1;
        expected_beats.push_back(b);
        bad_query_count++;
    endfunction

    // Unrank one query and queue every beat it should produce
    function automatic void predict_zigzag(input logic [LEN_W-1:0] len,
                                           input logic [RANK_W-1:0] rank);
        zz_beat_t          b;
        logic [63:0]       acc;
        logic [63:0]       dn;
        logic [63:0]       upc;
        logic [63:0]       rk;
        logic [MAX_LEN:0]  taken;
        int                n;
        int                first;
        int                prev;
        int                chosen;
        int                pos;
        bit                down;
        n = int'(len);
        if (n < 1 || n > MAX_LEN || rank == '0)
        begin
            push_bad();
            return;
        end
        if (n == 1)
        begin
            if (rank != 64'd1)
            begin
                push_bad();
                return;
            end
            b.value = VAL_W'(1);
            b.last  = 1'b1;
            b.bad   = 1'b0;
            expected_beats.push_back(b);
            return;
        end
        if (rank > zigzag_total(n))
        begin
            push_bad();
            return;
        end

        // pick the first value and the first direction
        acc   = '0;
        first = 0;
        down  = 1'b0;
        for (int i = 1; i <= n; i++)
        begin
            dn  = zz_count[n][i][1];
            upc = zz_count[n][i][0];
            if (acc + dn + upc >= rank)
            begin
                first = i;
                if (acc + dn >= rank)
                    down = 1'b1;
                else
                begin
                    down = 1'b0;
                    acc += dn;
                end
                break;
            end
            acc += dn + upc;
        end
        prev         = first;
        taken        = '0;
        taken[first] = 1'b1;
        b.value = VAL_W'(first);
        b.last  = 1'b0;
        b.bad   = 1'b0;
        expected_beats.push_back(b);

        // walk the unused values for each later position
        for (int step = 1; step < n; step++)
        begin
            pos    = 0;
            chosen = 0;
            for (int v = 1; v <= n; v++)
            begin
                if (taken[v])
                    continue;
                pos++;
                if (down ? (v > prev) : (v < prev))
                    continue;
                rk = zz_count[n-step][pos][down ? 0 : 1];
                if (acc + rk >= rank)
                begin
                    chosen = v;
                    break;
                end
                acc += rk;
            end
            if (chosen != 0)
                taken[chosen] = 1'b1;
            prev = chosen;
            down = !down;
            b.value = VAL_W'(chosen);
            b.last  = (step == n - 1);
            b.bad   = 1'b0;
            expected_beats.push_back(b);
        end
    endfunction

    function automatic void flag_error(input string msg);
        error_count++;
        if (error_count <= 10)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    // Send one query; hold it until accepted
    task automatic send_query(input logic [LEN_W-1:0] len, input logic [RANK_W-1:0] rank);
        int gap;
        if (idle_en && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 5);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= S_TDATA_W'({rank, len});
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_zigzag(len, rank);
        query_count++;
    endtask

    // Random 64-bit rank in 1..limit
    function automatic logic [63:0] pick_rank(input logic [63:0] limit);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return (raw % limit) + 64'd1;
    endfunction

    // Mostly well-formed queries, with some bad lengths and bad ranks mixed in
    task automatic send_random_query();
        int          roll;
        int          n;
        logic [63:0] total;
        logic [63:0] rank;
        roll = $urandom_range(0, 99);
        if (roll < 8)
        begin
            n    = $urandom_range(0, 1) ? 0 : $urandom_range(MAX_LEN + 1, 31);
            rank = {$urandom, $urandom};
        end
        else if (roll < 12)
        begin
            n    = 1;
            rank = $urandom_range(0, 3) == 0 ? {$urandom, $urandom} : 64'd1;
        end
        else
        begin
            n     = $urandom_range(0, 9) < 7 ? $urandom_range(2, 12)
                                             : $urandom_range(13, MAX_LEN);
            total = zigzag_total(n);
            if (roll < 18)
                rank = {$urandom, $urandom};
            else if (roll < 22)
                rank = $urandom_range(0, 1) ? 64'd0 : total + $urandom_range(1, 3);
            else if (roll < 28)
                rank = $urandom_range(0, 1) ? 64'd1 : total;
            else
                rank = pick_rank(total);
        end
        send_query(LEN_W'(n), rank);
    endtask

    // Short lengths, illegal lengths, rank zero
    task automatic test_short_and_illegal();
        send_query(LEN_W'(1), 64'd1);
        send_query(LEN_W'(1), 64'd2);
        send_query(LEN_W'(1), 64'd0);
        send_query(LEN_W'(0), 64'd1);
        send_query(LEN_W'(MAX_LEN + 1), 64'd1);
        send_query(LEN_W'(31), '1);
        send_query(LEN_W'(2), 64'd1);
        send_query(LEN_W'(2), 64'd2);
        send_query(LEN_W'(2), 64'd3);
        send_query(LEN_W'(5), 64'd0);
    endtask

    // First, last and one-past-last rank at several lengths, with a middle rank, all ones and next-to-last
    task automatic test_rank_extremes();
        send_query(LEN_W'(3), 64'd1);
        send_query(LEN_W'(3), zigzag_total(3));
        send_query(LEN_W'(3), zigzag_total(3) + 64'd1);
        send_query(LEN_W'(10), 64'd1);
        send_query(LEN_W'(10), zigzag_total(10) >> 1);
        send_query(LEN_W'(MAX_LEN), 64'd1);
        send_query(LEN_W'(MAX_LEN), zigzag_total(MAX_LEN));
        send_query(LEN_W'(MAX_LEN), zigzag_total(MAX_LEN) + 64'd1);
        send_query(LEN_W'(MAX_LEN), '1);
        send_query(LEN_W'(MAX_LEN - 1), zigzag_total(MAX_LEN - 1) - 64'd1);
    endtask

    task automatic test_random_queries(input int count);
        idle_en = 1'b1;
        repeat (count) send_random_query();
    endtask

    // Queries back to back with no idle gaps and no new result stalls
    task automatic test_back_to_back(input int count);
        idle_en = 1'b0;
        repeat (count) send_random_query();
    endtask

    // Result side: random stall bursts while idling is on
    initial
    begin
        out_stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (out_stall_left == 0 && idle_en && $urandom_range(0, 3) == 0)
                out_stall_left = $urandom_range(1, 5);
            if (out_stall_left > 0)
            begin
                m_axis_tready <= 1'b0;
                out_stall_left--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            beat_count++;
            if (expected_beats.size() == 0)
                flag_error($sformatf("unexpected beat value=%0d last=%0b bad=%0b",
                                     m_axis_tdata, m_axis_tlast, m_axis_tuser));
            else
            begin
                head_beat = expected_beats.pop_front();
                if (m_axis_tdata !== M_TDATA_W'(head_beat.value))
                    flag_error($sformatf("value exp %0d got %0d",
                                         head_beat.value, m_axis_tdata));
                if (m_axis_tlast !== head_beat.last)
                    flag_error($sformatf("last exp %0b got %0b",
                                         head_beat.last, m_axis_tlast));
                if (m_axis_tuser !== head_beat.bad)
                    flag_error($sformatf("bad_rank exp %0b got %0b",
                                         head_beat.bad, m_axis_tuser));
            end
        end
    end

    // Hard stop well beyond the slowest legal run
    initial
    begin
        #20_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        idle_en         = 1'b1;
        error_count     = 0;
        query_count     = 0;
        bad_query_count = 0;
        beat_count      = 0;
        build_zigzag_counts();

        // hold reset, then release on a clock edge
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_short_and_illegal();
        test_rank_extremes();
        test_random_queries(330);
        test_back_to_back(80);
        s_axis_tvalid <= 1'b0;

        // drain, then watch for stray beats
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Ran %0d queries (%0d rejected as bad), checked %0d result beats.",
                 query_count, bad_query_count, beat_count);
        $display("Lengths 0..31, ranks from zero to all ones, %0d failures.", error_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
